// ===== src/pknn_pkg.sv =====
// ----------------------------------------------------------------------------
// pknn_pkg: shared types and codes of the product-key nearest-neighbor unit
// Field widths, command and status codes, and fixed key constants.
// ----------------------------------------------------------------------------
package pknn_pkg;

    localparam int KEY_W     = 48;
    localparam int FEAT_W    = 32;
    localparam int LABEL_W   = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    // Packed stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 40;

    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [FEAT_W-1:0]   feat_t;
    typedef logic [LABEL_W-1:0]  label_t;
    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    // One table entry as held in the key/label memory.
    typedef struct packed {
        label_t label;
        key_t   key;
    } entry_t;

    localparam cmd_t CMD_TRAIN = 2'd0;
    localparam cmd_t CMD_QUERY = 2'd1;
    localparam cmd_t CMD_CLEAR = 2'd2;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

    // Sign bit of a key, which is also the magnitude of the most negative key.
    localparam key_t KEY_SIGN    = 48'h8000_0000_0000;
    localparam key_t KEY_MAX_POS = 48'h7FFF_FFFF_FFFF;

endpackage

// ===== src/pknn_ram.sv =====
// ----------------------------------------------------------------------------
// pknn_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pknn_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/pknn_mul.sv =====
// ----------------------------------------------------------------------------
// pknn_mul: iterative saturating fixed-point multiplier
// Multiplies a signed Q32.F key by a signed Q16.F feature with one shared
// 24x32 multiplier used twice, truncates the fraction and saturates.
// ----------------------------------------------------------------------------
module pknn_mul #(
    parameter int FRACTION_BITS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  pknn_pkg::key_t  key,
    input  pknn_pkg::feat_t feature,
    output logic            done,
    output pknn_pkg::key_t  result
);

    localparam int SHIFT_S = 24 - FRACTION_BITS;
    localparam int SUM_W   = 57;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_HI    = 3'd1;
    localparam logic [2:0] PH_LO    = 3'd2;
    localparam logic [2:0] PH_SUM   = 3'd3;
    localparam logic [2:0] PH_CLAMP = 3'd4;

    localparam logic [SUM_W-1:0] LIM_NEG = SUM_W'(pknn_pkg::KEY_SIGN);
    localparam logic [SUM_W-1:0] LIM_POS = SUM_W'(pknn_pkg::KEY_MAX_POS);

    logic [2:0]             phase_reg, phase_next;
    pknn_pkg::key_t         kmag_reg;
    pknn_pkg::feat_t        fmag_reg;
    logic                   neg_reg;
    logic [55:0]            x_reg;
    logic [55:0]            pp_reg;
    logic [SUM_W-1:0]       mag_reg;
    logic                   sat_reg;
    pknn_pkg::key_t         result_reg;
    logic                   done_reg;

    logic [23:0]            mul_a;
    logic [55:0]            mul_out;
    logic [SUM_W-1:0]       mag_clamped;

    // Shared multiplier: upper key half first, then the lower half.
    assign mul_a   = (phase_reg == PH_HI) ? kmag_reg[47:24] : kmag_reg[23:0];
    assign mul_out = 56'(mul_a) * 56'(fmag_reg);

    // Clamp the magnitude to the range of the result's sign.
    always_comb begin
        if (neg_reg) begin
            mag_clamped = (sat_reg || mag_reg > LIM_NEG) ? LIM_NEG : mag_reg;
        end else begin
            mag_clamped = (sat_reg || mag_reg > LIM_POS) ? LIM_POS : mag_reg;
        end
    end

    // Phase sequencer.
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:  if (start) phase_next = PH_HI;
            PH_HI:    phase_next = PH_LO;
            PH_LO:    phase_next = PH_SUM;
            PH_SUM:   phase_next = PH_CLAMP;
            PH_CLAMP: phase_next = PH_IDLE;
            default:  phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == PH_CLAMP);
        end
    end

    // Datapath registers; magnitudes are taken when a transfer starts.
    always_ff @(posedge aclk) begin
        if (phase_reg == PH_IDLE && start) begin
            kmag_reg <= key[pknn_pkg::KEY_W-1] ? (~key + 1'b1) : key;
            fmag_reg <= feature[pknn_pkg::FEAT_W-1] ? (~feature + 1'b1) : feature;
            neg_reg  <= key[pknn_pkg::KEY_W-1] ^ feature[pknn_pkg::FEAT_W-1];
        end
        if (phase_reg == PH_HI) begin
            x_reg <= mul_out;
        end
        if (phase_reg == PH_LO) begin
            pp_reg <= mul_out;
        end
        if (phase_reg == PH_SUM) begin
            sat_reg <= (x_reg >> (47 - SHIFT_S)) != '0;
            mag_reg <= (SUM_W'(x_reg) << SHIFT_S) + SUM_W'(pp_reg >> FRACTION_BITS);
        end
        if (phase_reg == PH_CLAMP) begin
            result_reg <= neg_reg ? (~mag_clamped[pknn_pkg::KEY_W-1:0] + 1'b1)
                                  : mag_clamped[pknn_pkg::KEY_W-1:0];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== src/product_key_nearest_neighbor_unit.sv =====
// ----------------------------------------------------------------------------
// product_key_nearest_neighbor_unit: product-key nearest-neighbor classifier
// Builds row keys from feature products, stores training rows and answers
// queries with the label of the nearest stored key.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one feature per transfer: s_tdata holds the
// feature and the label, s_tuser the command, s_tlast marks a row's end.
// The master channel returns one result per finished training or query row;
// clear commands and features that do not end a row return nothing.
// A zero feature skips the multiplier; a nonzero one goes through the two
// passes of the shared 24x32 multiplier and its sum and clamp steps. The
// last item of a query on a nonempty table then runs a scan: the stored
// keys are read one per cycle from the table memory and go through one
// distance unit and one comparator. The last item of a training row or of
// a query on an empty table goes straight to the result step.
// s_tready is high only while no item is in progress.
// Reset empties the table and sets the running product to one; no clearing
// pass is needed. A finished result waits in an output register, so a
// stalled receiver does not stop the next item from being taken; only a
// second result then waits until the first transfer completes.
// ----------------------------------------------------------------------------
module product_key_nearest_neighbor_unit #(
    parameter int TABLE_DEPTH   = 256,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: feature [31:0], label [63:32]
    input  logic [pknn_pkg::S_TDATA_W-1:0]      s_tdata,
    // s_tuser: command [1:0]
    input  logic [pknn_pkg::CMD_W-1:0]          s_tuser,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: predicted_label [31:0], status [33:32], zero [39:34]
    output logic [pknn_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam pknn_pkg::key_t ONE_VALUE = pknn_pkg::key_t'(48'd1 << FRACTION_BITS);
    localparam int ENTRY_W = $bits(pknn_pkg::entry_t);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_FINISH = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0]        state_reg, state_next;
    pknn_pkg::cmd_t    cmd_reg, cmd_next;
    pknn_pkg::label_t  label_reg, label_next;
    logic              last_reg, last_next;
    pknn_pkg::key_t    product_reg, product_next;
    pknn_pkg::key_t    key_reg, key_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     scan_idx_reg, scan_idx_next;
    logic              scan_active_reg, scan_active_next;
    pknn_pkg::label_t  res_label_reg, res_label_next;
    pknn_pkg::status_t res_status_reg, res_status_next;

    // Scan pipeline: read, distance, compare.
    logic              rd_valid_reg, rd_first_reg, rd_last_reg;
    logic              dist_valid_reg, dist_first_reg, dist_last_reg;
    pknn_pkg::key_t    dist_reg;
    pknn_pkg::label_t  dist_label_reg;
    pknn_pkg::key_t    best_reg;

    logic              out_valid_reg;
    pknn_pkg::label_t  out_label_reg;
    pknn_pkg::status_t out_status_reg;

    logic              s_xfer;
    logic              out_free;
    pknn_pkg::cmd_t    in_cmd;
    pknn_pkg::feat_t   in_feature;
    logic              mul_start;
    logic              mul_done;
    pknn_pkg::key_t    mul_result;

    logic              ram_wr_en;
    logic              ram_rd_en;
    pknn_pkg::entry_t  ram_wr_entry;
    pknn_pkg::entry_t  ram_rd_entry;
    logic [ENTRY_W-1:0] ram_rd_data;

    pknn_pkg::key_t    ua, ub;
    logic [pknn_pkg::KEY_W:0] diff_ab;
    pknn_pkg::key_t    dist_now;
    logic              take_new;

    assign in_cmd     = s_tuser;
    assign in_feature = s_tdata[pknn_pkg::FEAT_W-1:0];
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_xfer     = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign mul_start  = s_xfer && (in_cmd == pknn_pkg::CMD_TRAIN || in_cmd == pknn_pkg::CMD_QUERY)
                        && (in_feature != '0);

    pknn_mul #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .key     (product_reg),
        .feature (in_feature),
        .done    (mul_done),
        .result  (mul_result)
    );

    // Table memory: a write when a training row ends, reads during a scan.
    assign ram_wr_en          = (state_reg == ST_FINISH) && last_reg
                                && (cmd_reg == pknn_pkg::CMD_TRAIN) && (count_reg < DEPTH_C);
    assign ram_wr_entry.key   = product_reg;
    assign ram_wr_entry.label = label_reg;
    assign ram_rd_en          = scan_active_reg;
    assign ram_rd_entry       = pknn_pkg::entry_t'(ram_rd_data);

    pknn_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (ram_wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (scan_idx_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // Distance in offset-binary order, both differences side by side.
    assign ua       = ram_rd_entry.key ^ pknn_pkg::KEY_SIGN;
    assign ub       = key_reg ^ pknn_pkg::KEY_SIGN;
    assign diff_ab  = {1'b0, ua} - {1'b0, ub};
    assign dist_now = diff_ab[pknn_pkg::KEY_W] ? (ub - ua) : diff_ab[pknn_pkg::KEY_W-1:0];

    // A strictly smaller distance wins, so the earliest entry keeps a tie.
    assign take_new = dist_first_reg || (dist_reg < best_reg);

    // Sequencer.
    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        label_next       = label_reg;
        last_next        = last_reg;
        product_next     = product_reg;
        key_next         = key_reg;
        count_next       = count_reg;
        scan_idx_next    = scan_idx_reg;
        scan_active_next = scan_active_reg;
        res_label_next   = res_label_reg;
        res_status_next  = res_status_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    cmd_next   = in_cmd;
                    label_next = s_tdata[pknn_pkg::S_TDATA_W-1:pknn_pkg::FEAT_W];
                    last_next  = s_tlast;
                    case (in_cmd) inside
                        pknn_pkg::CMD_CLEAR: begin
                            count_next   = '0;
                            product_next = ONE_VALUE;
                        end
                        pknn_pkg::CMD_TRAIN, pknn_pkg::CMD_QUERY: begin
                            state_next = (in_feature != '0) ? ST_MUL : ST_FINISH;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    product_next = mul_result;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    key_next       = product_reg;
                    product_next   = ONE_VALUE;
                    res_label_next = '0;
                    if (cmd_reg == pknn_pkg::CMD_TRAIN) begin
                        if (count_reg < DEPTH_C) begin
                            count_next      = count_reg + 1'b1;
                            res_status_next = pknn_pkg::STATUS_OK;
                        end else begin
                            res_status_next = pknn_pkg::STATUS_FULL;
                        end
                        state_next = ST_RESULT;
                    end else if (count_reg == '0) begin
                        res_status_next = pknn_pkg::STATUS_EMPTY;
                        state_next      = ST_RESULT;
                    end else begin
                        res_status_next  = pknn_pkg::STATUS_OK;
                        scan_idx_next    = '0;
                        scan_active_next = 1'b1;
                        state_next       = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_active_reg) begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    if (scan_idx_reg == count_reg - 1'b1) begin
                        scan_active_next = 1'b0;
                    end
                end
                if (dist_valid_reg) begin
                    if (take_new) begin
                        res_label_next = dist_label_reg;
                    end
                    if (dist_last_reg) begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            product_reg     <= ONE_VALUE;
            count_reg       <= '0;
            scan_active_reg <= 1'b0;
            rd_valid_reg    <= 1'b0;
            dist_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            product_reg     <= product_next;
            count_reg       <= count_next;
            scan_active_reg <= scan_active_next;
            rd_valid_reg    <= scan_active_reg;
            dist_valid_reg  <= rd_valid_reg;
            if (state_reg == ST_RESULT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and scan pipeline registers.
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        label_reg      <= label_next;
        last_reg       <= last_next;
        key_reg        <= key_next;
        scan_idx_reg   <= scan_idx_next;
        res_label_reg  <= res_label_next;
        res_status_reg <= res_status_next;

        rd_first_reg   <= (scan_idx_reg == '0);
        rd_last_reg    <= (scan_idx_reg == count_reg - 1'b1);

        dist_reg       <= dist_now;
        dist_label_reg <= ram_rd_entry.label;
        dist_first_reg <= rd_first_reg;
        dist_last_reg  <= rd_last_reg;

        if (dist_valid_reg && take_new) begin
            best_reg <= dist_reg;
        end

        if (state_reg == ST_RESULT && out_free) begin
            out_label_reg  <= res_label_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_status_reg, out_label_reg};

    // A scan only runs on a table that holds entries.
    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (count_reg != '0))
        else $error("scan running on an empty table");

    // The entry count never passes the table depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count beyond table depth");

    // The multiplier only finishes while the sequencer waits for it.
    a_mul_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_MUL))
        else $error("multiplier finished outside its wait state");

    // A clear empties the table and restarts the product.
    a_clear_effect: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && in_cmd == pknn_pkg::CMD_CLEAR)
        |=> (count_reg == '0 && product_reg == ONE_VALUE))
        else $error("clear did not empty the table");

    // A scan result is handed over only after the last compare.
    a_scan_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && state_next == ST_RESULT)
        |-> (dist_valid_reg && dist_last_reg && !scan_active_reg))
        else $error("scan ended before its last compare");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the product-key nearest-neighbor unit
// Streams training, query, clear and reserved-command transfers into the
// block, predicts every answer from a bit-exact model of the key product and
// the nearest-key search, and checks each returned label and status in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TABLE_DEPTH   = 256;
    localparam int FRAC_BITS     = 16;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 300;

    // The fourth command code has no meaning and is ignored by the block.
    localparam pknn_pkg::cmd_t CMD_RESERVED = 2'd3;

    localparam pknn_pkg::key_t  KEY_ONE  = pknn_pkg::key_t'(64'd1 << FRAC_BITS);
    localparam pknn_pkg::feat_t FEAT_ONE = pknn_pkg::feat_t'(64'd1 << FRAC_BITS);
    localparam logic [63:0] MAG_LIMIT = {16'd0, pknn_pkg::KEY_SIGN};

    typedef struct packed {
        pknn_pkg::cmd_t   cmd;
        pknn_pkg::feat_t  feature;
        pknn_pkg::label_t label;
        logic             is_last;
        logic             drain;      // wait for all answers before offering this one
    } feature_item_t;

    typedef struct packed {
        pknn_pkg::label_t  label;
        pknn_pkg::status_t status;
    } answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [pknn_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [pknn_pkg::CMD_W-1:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [pknn_pkg::M_TDATA_W-1:0] m_tdata;

    // Items waiting to be offered and answers waiting to come back.
    feature_item_t feature_fifo[$];
    answer_t       answer_fifo[$];

    // Shadow state of the classifier.
    pknn_pkg::key_t   row_product = KEY_ONE;
    pknn_pkg::key_t   key_table[TABLE_DEPTH];
    pknn_pkg::label_t label_table[TABLE_DEPTH];
    int               entry_total = 0;

    feature_item_t cur_item;
    int  items_pushed = 0;
    int  items_taken = 0;
    int  error_count = 0;
    int  src_gap = 0;
    int  snk_gap = 0;
    int  hold_left = 0;
    int  hold_requests = 0;
    int  holds_done = 0;
    int  quiet_cycles = 0;
    bit  src_idle_on = 1'b0;
    bit  snk_idle_on = 1'b0;

    product_key_nearest_neighbor_unit #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .FRACTION_BITS(FRAC_BITS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Free-running clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Signed Q32.16 key times signed Q16.16 feature, truncated and clamped.
    function automatic pknn_pkg::key_t product_times_feature(pknn_pkg::key_t prod,
                                                             pknn_pkg::feat_t feat);
        pknn_pkg::key_t  pabs;
        pknn_pkg::feat_t fabs;
        logic [63:0]     upper;
        logic [63:0]     lower;
        logic [63:0]     mag;
        logic            clamp;
        int              shift;
        pabs  = prod[pknn_pkg::KEY_W-1] ? ~prod + 48'd1 : prod;
        fabs  = feat[pknn_pkg::FEAT_W-1] ? ~feat + 32'd1 : feat;
        shift = 24 - FRAC_BITS;
        upper = ({16'd0, pabs} >> 24) * {32'd0, fabs};
        lower = ({16'd0, pabs} & 64'hFF_FFFF) * {32'd0, fabs};
        clamp = (upper >> (47 - shift)) != 0;
        mag   = clamp ? 64'd0 : (upper << shift) + (lower >> FRAC_BITS);
        if (prod[pknn_pkg::KEY_W-1] != feat[pknn_pkg::FEAT_W-1]) begin
            if (clamp || mag > MAG_LIMIT) mag = MAG_LIMIT;
            return pknn_pkg::key_t'(~mag + 64'd1);
        end
        if (clamp || mag > MAG_LIMIT - 64'd1) mag = MAG_LIMIT - 64'd1;
        return pknn_pkg::key_t'(mag);
    endfunction

    // Absolute distance between two signed keys.
    function automatic pknn_pkg::key_t key_gap(pknn_pkg::key_t a, pknn_pkg::key_t b);
        pknn_pkg::key_t ua;
        pknn_pkg::key_t ub;
        ua = a ^ pknn_pkg::KEY_SIGN;
        ub = b ^ pknn_pkg::KEY_SIGN;
        return (ua > ub) ? ua - ub : ub - ua;
    endfunction

    // Advance the shadow classifier by one accepted transfer.
    task automatic classify_item(input feature_item_t it);
        pknn_pkg::key_t row_key;
        pknn_pkg::key_t best_gap;
        pknn_pkg::key_t gap;
        answer_t        ans;
        if (it.cmd == pknn_pkg::CMD_CLEAR) begin
            entry_total = 0;
            row_product = KEY_ONE;
        end else if (it.cmd == pknn_pkg::CMD_TRAIN || it.cmd == pknn_pkg::CMD_QUERY) begin
            if (it.feature != '0) row_product = product_times_feature(row_product, it.feature);
            if (it.is_last) begin
                row_key     = row_product;
                row_product = KEY_ONE;
                ans.label   = '0;
                ans.status  = pknn_pkg::STATUS_OK;
                if (it.cmd == pknn_pkg::CMD_TRAIN) begin
                    if (entry_total < TABLE_DEPTH) begin
                        key_table[entry_total]   = row_key;
                        label_table[entry_total] = it.label;
                        entry_total++;
                    end else begin
                        ans.status = pknn_pkg::STATUS_FULL;
                    end
                end else if (entry_total == 0) begin
                    ans.status = pknn_pkg::STATUS_EMPTY;
                end else begin
                    // Strictly smaller distance only, so the earliest entry wins a tie.
                    best_gap  = key_gap(row_key, key_table[0]);
                    ans.label = label_table[0];
                    for (int i = 1; i < entry_total; i++) begin
                        gap = key_gap(row_key, key_table[i]);
                        if (gap < best_gap) begin
                            best_gap  = gap;
                            ans.label = label_table[i];
                        end
                    end
                end
                answer_fifo.push_back(ans);
            end
        end
    endtask

    // Feature values: zero, extremes, small exact multiples of one half, raw bits.
    function automatic pknn_pkg::feat_t pick_feature(bit exact_only);
        pknn_pkg::feat_t f;
        int              sel;
        sel = exact_only ? 2 : $urandom_range(0, 9);
        case (sel) inside
            0: f = '0;
            1: begin
                case ($urandom_range(0, 3))
                    0: f = 32'h8000_0000;
                    1: f = 32'h7FFF_FFFF;
                    2: f = 32'hFFFF_FFFF;
                    default: f = 32'h0000_0001;
                endcase
            end
            [2:5]: begin
                f = pknn_pkg::feat_t'($urandom_range(1, 8)) << (FRAC_BITS - 1);
                if ($urandom_range(0, 1) == 1) f = ~f + 32'd1;
            end
            default: f = $urandom();
        endcase
        return f;
    endfunction

    task automatic push_item(pknn_pkg::cmd_t cmd, pknn_pkg::feat_t feat, pknn_pkg::label_t lab,
                             logic is_last, logic drain);
        feature_item_t it;
        it.cmd     = cmd;
        it.feature = feat;
        it.label   = lab;
        it.is_last = is_last;
        it.drain   = drain;
        feature_fifo.push_back(it);
        items_pushed++;
    endtask

    // One row; with mixing, earlier features carry random train/query codes.
    task automatic push_row(pknn_pkg::cmd_t row_cmd, int nfeat, bit mixed, bit exact_only,
                            bit drain);
        pknn_pkg::cmd_t cmd;
        for (int i = 0; i < nfeat; i++) begin
            cmd = row_cmd;
            if (mixed && i != nfeat - 1)
                cmd = ($urandom_range(0, 1) == 1) ? pknn_pkg::CMD_TRAIN : pknn_pkg::CMD_QUERY;
            push_item(cmd, pick_feature(exact_only), $urandom(), i == nfeat - 1, drain && i == 0);
        end
    endtask

    // Mostly well-formed rows, with clears, rows cut short and reserved commands.
    task automatic push_random_rows(int n_items, int clear_odds);
        int             sent;
        int             r;
        int             nf;
        pknn_pkg::cmd_t cmd;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                push_item(CMD_RESERVED, $urandom(), $urandom(), 1'($urandom_range(0, 1)), 1'b0);
            end else if (r < 3 + clear_odds) begin
                push_item(pknn_pkg::CMD_CLEAR, $urandom(), $urandom(),
                          1'($urandom_range(0, 1)), 1'b0);
                sent++;
            end else if (r < 10) begin
                nf = $urandom_range(1, 3);
                for (int i = 0; i < nf; i++)
                    push_item(($urandom_range(0, 1) == 1) ? pknn_pkg::CMD_TRAIN
                                                           : pknn_pkg::CMD_QUERY,
                              pick_feature(1'b0), $urandom(), 1'b0, 1'b0);
                if ($urandom_range(0, 1) == 1)
                    push_item(pknn_pkg::CMD_CLEAR, $urandom(), $urandom(), 1'b1, 1'b0);
                else
                    push_item(CMD_RESERVED, $urandom(), $urandom(), 1'b1, 1'b0);
                sent += nf;
            end else begin
                nf  = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : 1;
                cmd = ($urandom_range(0, 1) == 1) ? pknn_pkg::CMD_TRAIN : pknn_pkg::CMD_QUERY;
                push_row(cmd, nf, $urandom_range(0, 3) == 0, 1'b0, $urandom_range(0, 49) == 0);
                sent += nf;
            end
        end
    endtask

    task automatic wait_fifo_empty();
        while (feature_fifo.size() != 0) @(posedge aclk);
    endtask

    // Driver: offers queued items, predicts on each accepted transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                classify_item(cur_item);
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (feature_fifo.size() != 0 &&
                             !(feature_fifo[0].drain && answer_fifo.size() != 0)) begin
                    cur_item = feature_fifo.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_item.label, cur_item.feature};
                    s_tuser  <= cur_item.cmd;
                    s_tlast  <= cur_item.is_last;
                    if (src_idle_on && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 19);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer and paces m_tready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (answer_fifo.size() == 0) begin
                    $error("result with nothing pending: predicted_label %h status %0d",
                           m_tdata[31:0], m_tdata[33:32]);
                    error_count++;
                end else begin
                    if (m_tdata[31:0] !== answer_fifo[0].label) begin
                        $error("predicted_label: expected %h, actual %h",
                               answer_fifo[0].label, m_tdata[31:0]);
                        error_count++;
                    end
                    if (m_tdata[33:32] !== answer_fifo[0].status) begin
                        $error("status: expected %0d, actual %0d",
                               answer_fifo[0].status, m_tdata[33:32]);
                        error_count++;
                    end
                    void'(answer_fifo.pop_front());
                end
            end
            if (holds_done != hold_requests) begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end else if (snk_idle_on && $urandom_range(0, 7) == 0) begin
                snk_gap = $urandom_range(0, 18);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Stimulus sequence and end of run.
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty table, extremes, ties, mixed rows, ignored and clear commands.
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        push_item(pknn_pkg::CMD_QUERY, FEAT_ONE, 32'h1111_1111, 1'b1, 1'b0);
        push_item(pknn_pkg::CMD_TRAIN, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
        push_item(pknn_pkg::CMD_TRAIN, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0);
        push_item(pknn_pkg::CMD_TRAIN, 32'h0000_0000, 32'hA5A5_A5A5, 1'b1, 1'b0);
        push_item(pknn_pkg::CMD_TRAIN, FEAT_ONE, 32'h5A5A_5A5A, 1'b1, 1'b0);
        push_item(pknn_pkg::CMD_QUERY, FEAT_ONE, 32'h0, 1'b1, 1'b0);
        push_item(pknn_pkg::CMD_QUERY, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0);
        push_item(pknn_pkg::CMD_QUERY, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0);
        push_item(pknn_pkg::CMD_QUERY, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b0);
        push_item(pknn_pkg::CMD_QUERY, 32'h8000_0000, 32'h0, 1'b0, 1'b0);
        push_item(pknn_pkg::CMD_TRAIN, 32'h8000_0000, 32'h0, 1'b0, 1'b0);
        push_item(pknn_pkg::CMD_QUERY, 32'h8000_0000, 32'h0, 1'b0, 1'b0);
        push_item(pknn_pkg::CMD_QUERY, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b0);
        push_item(pknn_pkg::CMD_QUERY, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
        push_item(pknn_pkg::CMD_TRAIN, FEAT_ONE, 32'h1234_5678, 1'b1, 1'b0);
        push_item(CMD_RESERVED, FEAT_ONE, 32'hFFFF_FFFF, 1'b1, 1'b0);
        push_item(pknn_pkg::CMD_QUERY, 32'h0000_0001, 32'h0, 1'b1, 1'b0);
        push_item(pknn_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
        push_item(pknn_pkg::CMD_QUERY, 32'h0000_0000, 32'h0, 1'b1, 1'b0);
        push_item(pknn_pkg::CMD_TRAIN, FEAT_ONE, 32'h0, 1'b0, 1'b0);
        push_item(pknn_pkg::CMD_CLEAR, 32'h0, 32'h0, 1'b0, 1'b0);
        push_item(pknn_pkg::CMD_QUERY, 32'h0000_0000, 32'h0, 1'b1, 1'b0);
        wait_fifo_empty();

        // Random rows; the receiver stalls long at the start so the block backs up.
        push_random_rows(300, 4);
        hold_requests++;
        wait_fifo_empty();

        // Fill past capacity with exact keys so ties are common, querying as it grows.
        src_idle_on = 1'b0;
        push_item(pknn_pkg::CMD_CLEAR, $urandom(), $urandom(), 1'b1, 1'b1);
        for (int k = 0; k < TABLE_DEPTH + 14; k++) begin
            push_row(pknn_pkg::CMD_TRAIN, 1, 1'b0, 1'b1, 1'b0);
            if (k % 30 == 29)
                push_row(pknn_pkg::CMD_QUERY, $urandom_range(1, 2), 1'b0, 1'b1, 1'b0);
        end
        for (int k = 0; k < 8; k++)
            push_row(pknn_pkg::CMD_QUERY, $urandom_range(1, 3), 1'b0, 1'b0, 1'b0);
        push_item(pknn_pkg::CMD_CLEAR, $urandom(), $urandom(), 1'b0, 1'b0);
        wait_fifo_empty();

        // Random rows with idling on both sides and a second long stall.
        src_idle_on = 1'b1;
        push_random_rows(150, 4);
        hold_requests++;
        push_random_rows(150, 3);
        wait_fifo_empty();

        // Closing stretch with no idling.
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        push_random_rows(150, 4);

        while (items_taken != items_pushed) @(posedge aclk);
        while (answer_fifo.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (error_count == 0 && answer_fifo.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
